FILE: rtl/core/lla_pkg.sv
package lla_pkg;

  localparam int GridSide = 64;
  localparam int CoordW   = $clog2(GridSide);
  localparam int MaskW    = 9;
  localparam int CmdW     = 2;
  localparam int CfgIdxW  = 1;

  localparam logic [MaskW-1:0] BirthReset   = MaskW'(8);
  localparam logic [MaskW-1:0] SurviveReset = MaskW'(12);

  localparam logic [CmdW-1:0] CmdToggle = 2'd0;
  localparam logic [CmdW-1:0] CmdStep   = 2'd1;
  localparam logic [CmdW-1:0] CmdRead   = 2'd2;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  localparam logic [CfgIdxW-1:0] RegBirth   = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSurvive = 1'b1;

  typedef logic [GridSide-1:0] row_t;

  typedef struct packed {
    logic toggle;
    logic step;
    logic capture;
  } lla_cmd_t;

  function automatic logic next_cell(input logic alive, input logic [3:0] n,
                                     input logic [MaskW-1:0] birth,
                                     input logic [MaskW-1:0] survive);
    logic r;
    if (alive) begin
      r = survive[n];
    end else begin
      r = (n != 4'd0) && birth[n];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/life_like_automaton_grid.sv
// 64x64 Life-like cell array. A command is taken when start_i is high and
// busy_o is low; toggle, step and read each return one transaction:
// cell_alive_o is valid for one cycle with done_o, and cannot be stalled.
// A step updates every cell at once via the neighbor adders. Masks are
// written via cfg_we_i by the user while idle; the block does not check.
module life_like_automaton_grid (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [lla_pkg::CmdW-1:0]    command_i,
  input  logic [lla_pkg::CoordW-1:0]  x_i,
  input  logic [lla_pkg::CoordW-1:0]  y_i,
  output logic                        done_o,
  output logic                        cell_alive_o,
  input  logic                        cfg_we_i,
  input  logic [lla_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lla_pkg::MaskW-1:0]   cfg_data_i
);
  import lla_pkg::*;

  logic [MaskW-1:0] birth_q, survive_q;
  lla_cmd_t         cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q   <= BirthReset;
      survive_q <= SurviveReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBirth:   birth_q   <= cfg_data_i;
        RegSurvive: survive_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lla_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .command_i,
    .busy_o, .done_o, .cmd_o(cmd)
  );

  lla_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .start_i, .busy_i(busy_o), .x_i, .y_i,
    .birth_i(birth_q), .survive_i(survive_q), .cell_alive_o
  );

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("done without busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accept did not set busy");
  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double done");

endmodule

FILE: rtl/core/lla_ctrl.sv
module lla_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [lla_pkg::CmdW-1:0] command_i,
  output logic                    busy_o,
  output logic                    done_o,
  output lla_pkg::lla_cmd_t       cmd_o
);
  import lla_pkg::*;

  typedef enum logic [0:0] {
    StIdle,
    StResp
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StResp;
          end
        end
        StResp: begin
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  logic accept;
  assign accept = start_i && (state_q == StIdle);

  assign busy_o        = (state_q != StIdle);
  assign done_o        = done_q;
  assign cmd_o.toggle  = accept && (command_i == CmdToggle);
  assign cmd_o.step    = accept && (command_i == CmdStep);
  assign cmd_o.capture = (state_q == StResp);

endmodule

FILE: rtl/core/lla_datapath.sv
module lla_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lla_pkg::lla_cmd_t          cmd_i,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [lla_pkg::CoordW-1:0] x_i,
  input  logic [lla_pkg::CoordW-1:0] y_i,
  input  logic [lla_pkg::MaskW-1:0]  birth_i,
  input  logic [lla_pkg::MaskW-1:0]  survive_i,
  output logic                       cell_alive_o
);
  import lla_pkg::*;

  row_t              grid_q [GridSide];
  logic [CoordW-1:0] x_q, y_q;
  logic              alive_q;

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_i) begin
      x_q <= x_i;
      y_q <= y_i;
    end
    if (cmd_i.capture) begin
      alive_q <= grid_q[y_q][x_q];
    end
  end

  function automatic logic [3:0] count(input row_t up, input row_t mid, input row_t dn,
                                       input int c);
    logic [3:0] n;
    n = 4'd0;
    for (int d = -1; d <= 1; d++) begin
      if (c + d >= 0 && c + d < GridSide) begin
        n = n + 4'(up[c+d]) + 4'(dn[c+d]);
        if (d != 0) begin
          n = n + 4'(mid[c+d]);
        end
      end
    end
    return n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < GridSide; r++) begin
        grid_q[r] <= '0;
      end
    end else if (cmd_i.step) begin
      for (int r = 0; r < GridSide; r++) begin
        for (int c = 0; c < GridSide; c++) begin
          grid_q[r][c] <= next_cell(grid_q[r][c],
            count((r > 0) ? grid_q[(r > 0) ? r-1 : 0] : '0, grid_q[r],
                  (r < GridSide-1) ? grid_q[(r < GridSide-1) ? r+1 : r] : '0, c),
            birth_i, survive_i);
        end
      end
    end else if (cmd_i.toggle) begin
      grid_q[y_i][x_i] <= ~grid_q[y_i][x_i];
    end
  end

  assign cell_alive_o = alive_q;

endmodule
